FILE: hw/rtl/radial_tukey_kspace_weight_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radial Tukey k-space weight block
// Concurrent assertion helpers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RADIAL_TUKEY_KSPACE_WEIGHT_MACROS_SVH
`define RADIAL_TUKEY_KSPACE_WEIGHT_MACROS_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define RTKW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define RTKW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTKW_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTKW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/rtkw_pkg.sv
// ----------------------------------------------------------------------------
// rtkw_pkg
// Shared types, widths and constants of the radial Tukey k-space weight block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtkw_pkg;

    localparam int MAX_SIZE_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int IDX_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int RAD_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NRM_W      = 22;   // normalized axis magnitude, Q.14
    localparam int SSQ_W      = 46;   // sum of three squares
    localparam int ROOT_W     = 23;   // radius
    localparam int PH_W       = 31;   // taper phase, Q30, up to one
    localparam int W_W        = 16;   // weight, Q15, up to one
    localparam int DIV_STEP   = 2;    // quotient bits per divider stage
    localparam int SQRT_STEP  = 2;    // root bits per square root stage

    localparam logic [W_W-1:0]  ONE_Q15  = 16'h8000;
    localparam logic [PH_W-1:0] HALF_Q30 = 31'h2000_0000;

    // Odd Taylor coefficients of sin(pi*u), Q28.
    localparam logic [30:0] K_A1 = 31'd843314857;
    localparam logic [30:0] K_A3 = 31'd1387197337;
    localparam logic [30:0] K_A5 = 31'd684554446;
    localparam logic [30:0] K_A7 = 31'd160863847;
    localparam logic [30:0] K_A9 = 31'd22050869;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SIZE_X       = 3'd0,
        REG_SIZE_Y       = 3'd1,
        REG_SIZE_Z       = 3'd2,
        REG_START_RADIUS = 3'd3,
        REG_END_RADIUS   = 3'd4,
        REG_FLOOR_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WCLS_ONE   = 2'd0,
        WCLS_ZERO  = 2'd1,
        WCLS_TAPER = 2'd2
    } wclass_t;

endpackage

FILE: hw/rtl/rtkw_div.sv
// ----------------------------------------------------------------------------
// rtkw_div
// Pipelined restoring divider, STEP quotient bits per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtkw_div #(
    parameter int NUM_W  = 22,
    parameter int DEN_W  = 8,
    parameter int STEP   = 2,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NSTG  = (NUM_W + STEP - 1) / STEP;
    localparam int PAD_W = NSTG * STEP;

    logic [PAD_W-1:0]  num_reg  [NSTG];
    logic [PAD_W-1:0]  quo_reg  [NSTG];
    logic [DEN_W-1:0]  rem_reg  [NSTG];
    logic [DEN_W-1:0]  den_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];
    logic              vld_reg  [NSTG];

    logic [PAD_W-1:0]  num_next [NSTG];
    logic [PAD_W-1:0]  quo_next [NSTG];
    logic [DEN_W-1:0]  rem_next [NSTG];

    logic [PAD_W-1:0]  num_in  [NSTG];
    logic [PAD_W-1:0]  quo_in  [NSTG];
    logic [DEN_W-1:0]  rem_in  [NSTG];
    logic [DEN_W-1:0]  den_in  [NSTG];
    logic [SIDE_W-1:0] side_a  [NSTG];
    logic              vld_in  [NSTG];

    assign num_in[0] = PAD_W'(num);
    assign quo_in[0] = '0;
    assign rem_in[0] = '0;
    assign den_in[0] = den;
    assign side_a[0] = side_in;
    assign vld_in[0] = in_vld;

    for (genvar k = 1; k < NSTG; k++) begin : g_link
        assign num_in[k] = num_reg[k-1];
        assign quo_in[k] = quo_reg[k-1];
        assign rem_in[k] = rem_reg[k-1];
        assign den_in[k] = den_reg[k-1];
        assign side_a[k] = side_reg[k-1];
        assign vld_in[k] = vld_reg[k-1];
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        always_comb begin
            logic [PAD_W-1:0] n_v;
            logic [PAD_W-1:0] q_v;
            logic [DEN_W:0]   t_v;
            logic [DEN_W-1:0] r_v;
            n_v = num_in[k];
            q_v = quo_in[k];
            r_v = rem_in[k];
            for (int i = 0; i < STEP; i++) begin
                t_v = {r_v, n_v[PAD_W-1]};
                n_v = {n_v[PAD_W-2:0], 1'b0};
                if (t_v >= {1'b0, den_in[k]}) begin
                    t_v = t_v - {1'b0, den_in[k]};
                    q_v = {q_v[PAD_W-2:0], 1'b1};
                end else begin
                    q_v = {q_v[PAD_W-2:0], 1'b0};
                end
                r_v = t_v[DEN_W-1:0];
            end
            num_next[k] = n_v;
            quo_next[k] = q_v;
            rem_next[k] = r_v;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k]  <= num_next[k];
                quo_reg[k]  <= quo_next[k];
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_in[k];
                side_reg[k] <= side_a[k];
            end
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign quo      = quo_reg[NSTG-1][NUM_W-1:0];
    assign side_out = side_reg[NSTG-1];

endmodule

FILE: hw/rtl/rtkw_isqrt.sv
// ----------------------------------------------------------------------------
// rtkw_isqrt
// Pipelined digit-by-digit integer square root, floor of the root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtkw_isqrt #(
    parameter int IN_W   = 46,
    parameter int STEP   = 2,
    parameter int SIDE_W = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic [IN_W-1:0]    rad,
    input  logic [SIDE_W-1:0]  side_in,
    output logic               out_vld,
    output logic [IN_W/2-1:0]  root,
    output logic [SIDE_W-1:0]  side_out
);

    localparam int NSTEP = (IN_W + 1) / 2;
    localparam int NSTG  = (NSTEP + STEP - 1) / STEP;
    localparam int R_W   = NSTG * STEP;
    localparam int PAD_W = 2 * R_W;
    localparam int RM_W  = R_W + 4;

    logic [PAD_W-1:0]  rad_reg  [NSTG];
    logic [R_W-1:0]    root_reg [NSTG];
    logic [RM_W-1:0]   rem_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];
    logic              vld_reg  [NSTG];

    logic [PAD_W-1:0]  rad_next  [NSTG];
    logic [R_W-1:0]    root_next [NSTG];
    logic [RM_W-1:0]   rem_next  [NSTG];

    logic [PAD_W-1:0]  rad_in  [NSTG];
    logic [R_W-1:0]    root_in [NSTG];
    logic [RM_W-1:0]   rem_in  [NSTG];
    logic [SIDE_W-1:0] side_a  [NSTG];
    logic              vld_in  [NSTG];

    assign rad_in[0]  = PAD_W'(rad);
    assign root_in[0] = '0;
    assign rem_in[0]  = '0;
    assign side_a[0]  = side_in;
    assign vld_in[0]  = in_vld;

    for (genvar k = 1; k < NSTG; k++) begin : g_link
        assign rad_in[k]  = rad_reg[k-1];
        assign root_in[k] = root_reg[k-1];
        assign rem_in[k]  = rem_reg[k-1];
        assign side_a[k]  = side_reg[k-1];
        assign vld_in[k]  = vld_reg[k-1];
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        always_comb begin
            logic [PAD_W-1:0] a_v;
            logic [R_W-1:0]   q_v;
            logic [RM_W-1:0]  m_v;
            logic [RM_W-1:0]  tr_v;
            a_v = rad_in[k];
            q_v = root_in[k];
            m_v = rem_in[k];
            for (int i = 0; i < STEP; i++) begin
                m_v  = {m_v[RM_W-3:0], a_v[PAD_W-1 -: 2]};
                a_v  = {a_v[PAD_W-3:0], 2'b00};
                tr_v = {2'b00, q_v, 2'b01};
                if (m_v >= tr_v) begin
                    m_v = m_v - tr_v;
                    q_v = {q_v[R_W-2:0], 1'b1};
                end else begin
                    q_v = {q_v[R_W-2:0], 1'b0};
                end
            end
            rad_next[k]  = a_v;
            root_next[k] = q_v;
            rem_next[k]  = m_v;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_next[k];
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
                side_reg[k] <= side_a[k];
            end
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign root     = root_reg[NSTG-1][IN_W/2-1:0];
    assign side_out = side_reg[NSTG-1];

endmodule

FILE: hw/rtl/rtkw_taper.sv
// ----------------------------------------------------------------------------
// rtkw_taper
// Cosine taper: polynomial sine from the phase, then the Q15 weight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtkw_taper import rtkw_pkg::*; #(
    parameter int SIDE_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [PH_W-1:0]   phase,
    input  wclass_t           cls,
    input  logic [W_W-1:0]    hgt,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [W_W-1:0]    w,
    output logic [SIDE_W-1:0] side_out
);

    // Stage k register holds the work of step k; control and payload ride along.
    logic              vld_reg  [9];
    wclass_t           cls_reg  [8];
    logic [SIDE_W-1:0] side_reg [9];
    logic [29:0]       mag_reg  [6];
    logic              neg_reg  [7];
    logic [28:0]       u2_reg   [2:4];

    logic [59:0] sq_reg;
    logic [59:0] m9_reg, m7_reg, m5_reg, m3_reg;
    logic [60:0] s_reg;
    logic [32:0] hprod_reg;
    logic [W_W-1:0] w_reg;

    logic [29:0] mag_next;
    logic        neg_next;
    logic [59:0] sq_next;
    logic [28:0] u2_next;
    logic [59:0] m9_next, m7_next, m5_next, m3_next;
    logic [30:0] p7_next, p5_next, p3_next, p1_next;
    logic [60:0] s_next;
    logic [32:0] hprod_next;
    logic [W_W-1:0] w_next;

    logic [W_W-1:0] h_cl;
    logic [W_W-1:0] one_minus_h;
    logic [31:0]    s_rnd;
    logic [W_W-1:0] s15;
    logic [16:0]    fac;
    logic [32:0]    h_sum;

    assign h_cl        = (hgt > ONE_Q15) ? ONE_Q15 : hgt;
    assign one_minus_h = ONE_Q15 - h_cl;

    always_comb begin
        if (phase >= HALF_Q30) begin
            mag_next = 30'(phase - HALF_Q30);
            neg_next = 1'b1;
        end else begin
            mag_next = 30'(HALF_Q30 - phase);
            neg_next = 1'b0;
        end
        sq_next = mag_reg[0] * mag_reg[0];
        u2_next = sq_reg[58:30];
        m9_next = K_A9 * u2_next;
        p7_next = K_A7 - {1'b0, m9_reg[59:30]};
        m7_next = p7_next * u2_reg[2];
        p5_next = K_A5 - {1'b0, m7_reg[59:30]};
        m5_next = p5_next * u2_reg[3];
        p3_next = K_A3 - {1'b0, m5_reg[59:30]};
        m3_next = p3_next * u2_reg[4];
        p1_next = K_A1 - {1'b0, m3_reg[59:30]};
        s_next  = p1_next * mag_reg[5];
        // Round the Q28 sine to Q15 and cap it at one.
        s_rnd = {1'b0, s_reg[60:30]} + 32'd4096;
        s15   = (s_rnd[31:13] > 19'(ONE_Q15)) ? ONE_Q15 : s_rnd[28:13];
        fac   = neg_reg[6] ? (17'd32768 - {1'b0, s15}) : (17'd32768 + {1'b0, s15});
        hprod_next = one_minus_h * fac;
        h_sum = hprod_reg + 33'd32768;
        unique case (cls_reg[7])
            WCLS_ONE:   w_next = ONE_Q15;
            WCLS_ZERO:  w_next = '0;
            WCLS_TAPER: w_next = h_cl + h_sum[31:16];
            default:    w_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < 9; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls_reg[0]  <= cls;
            side_reg[0] <= side_in;
            mag_reg[0]  <= mag_next;
            neg_reg[0]  <= neg_next;
            for (int k = 1; k < 8; k++) begin
                cls_reg[k] <= cls_reg[k-1];
            end
            for (int k = 1; k < 9; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                mag_reg[k] <= mag_reg[k-1];
            end
            for (int k = 1; k < 7; k++) begin
                neg_reg[k] <= neg_reg[k-1];
            end
            u2_reg[2] <= u2_next;
            u2_reg[3] <= u2_reg[2];
            u2_reg[4] <= u2_reg[3];
            sq_reg    <= sq_next;
            m9_reg    <= m9_next;
            m7_reg    <= m7_next;
            m5_reg    <= m5_next;
            m3_reg    <= m3_next;
            s_reg     <= s_next;
            hprod_reg <= hprod_next;
            w_reg     <= w_next;
        end
    end

    assign out_vld  = vld_reg[8];
    assign w        = w_reg;
    assign side_out = side_reg[8];

endmodule

FILE: hw/rtl/radial_tukey_kspace_weight.sv
// ----------------------------------------------------------------------------
// radial_tukey_kspace_weight
// Weights 3-D k-space samples by a radial Tukey taper of their position.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel carries one complex sample and its
// x, y and z indices. Exactly one weighted sample leaves on the m_ channel for
// each input, in order. The block keeps no state between samples, so a new
// transfer can be taken in every cycle unless the receiver stalls.
// From an accepted input transfer to its result on m_tvalid, a sample passes
// one setup stage, an 11-stage divider for the axis normalization,
// two stages of squares and sum, a 12-stage square root, one compare stage,
// a 23-stage divider for the taper phase, 9 taper stages and 2 output stages.
// Throughput is one sample per cycle while the receiver does not stall.
// The cfg_ channel writes the six registers and is always ready. The user
// makes writes only while no samples are in flight; the block does not enforce it.
// Reset clears every valid flag and loads the register defaults; payload
// registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "radial_tukey_kspace_weight_macros.svh"

module radial_tukey_kspace_weight import rtkw_pkg::*; #(
    parameter int MAX_SIZE    = MAX_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input samples.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: idx_x, idx_y, idx_z, sample_re, sample_im, zero pad.
    input  logic [((3*IDX_W+2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // Weighted samples.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: out_re, out_im, zero pad.
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    // Register writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SB       = SAMPLE_BITS;
    localparam int OUT_W    = ((2*SB+7)/8)*8;
    localparam int CLAMP_I  = (MAX_SIZE > 511) ? 511 : MAX_SIZE;
    localparam logic [SIZE_W-1:0] SIZE_CLAMP = CLAMP_I[SIZE_W-1:0];

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [RAD_W-1:0]  start_reg, end_reg;
    logic [W_W-1:0]    floor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= 9'd64;
            size_y_reg <= 9'd64;
            size_z_reg <= 9'd64;
            start_reg  <= 16'd8192;
            end_reg    <= 16'd16384;
            floor_reg  <= 16'd0;
        end else if (cfg_valid) begin
            // Writes to an unknown register index are ignored.
            unique case (cfg_addr)
                REG_SIZE_X:       size_x_reg <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:       size_y_reg <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:       size_z_reg <= cfg_data[SIZE_W-1:0];
                REG_START_RADIUS: start_reg  <= cfg_data;
                REG_END_RADIUS:   end_reg    <= cfg_data;
                REG_FLOOR_HEIGHT: floor_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Half the axis size, with the size held between two and the maximum.
    function automatic logic [IDX_W-1:0] half_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] c;
        c = s;
        if (s < 9'd2) begin
            c = 9'd2;
        end else if (s > SIZE_CLAMP) begin
            c = SIZE_CLAMP;
        end
        return c[SIZE_W-1:1];
    endfunction

    // Numerator of the normalized magnitude: |i - h| * 2^14 + floor(h / 2).
    function automatic logic [NRM_W-1:0] norm_num(input logic [IDX_W-1:0] i,
                                                  input logic [IDX_W-1:0] h);
        logic [IDX_W-1:0] d;
        d = (i >= h) ? (i - h) : (h - i);
        return {d, 14'b0} + NRM_W'(h[IDX_W-1:1]);
    endfunction

    // Round half away from zero after the Q15 multiply, then saturate.
    function automatic logic [SB-1:0] round_sat(input logic [SB+15:0] p,
                                                input logic neg);
        logic [SB+16:0] r;
        logic [SB+1:0]  q;
        logic [SB-1:0]  qs;
        r  = {1'b0, p} + (SB+17)'(16384);
        q  = r[SB+16:15];
        qs = q[SB-1:0];
        if (!neg) begin
            return (q > {3'b000, {(SB-1){1'b1}}}) ? {1'b0, {(SB-1){1'b1}}} : qs;
        end
        return (q > {2'b00, 1'b1, {(SB-1){1'b0}}}) ? {1'b1, {(SB-1){1'b0}}}
                                                     : (~qs) + SB'(1);
    endfunction

    // The whole pipeline advances together unless a result waits at the port.
    logic pipe_en;
    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;

    // ------------------------------------------------------------------
    // Setup stage: half sizes and division numerators per axis.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] hx, hy, hz;
    logic             n0_vld_reg;
    logic [NRM_W-1:0] n0_num_x_reg, n0_num_y_reg, n0_num_z_reg;
    logic [NRM_W-1:0] n0_num_x_next, n0_num_y_next, n0_num_z_next;
    logic [IDX_W-1:0] n0_h_x_reg, n0_h_y_reg, n0_h_z_reg;
    logic [2*SB-1:0]  n0_smp_reg;

    assign hx = half_size(size_x_reg);
    assign hy = half_size(size_y_reg);
    assign hz = half_size(size_z_reg);

    assign n0_num_x_next = norm_num(s_tdata[7:0], hx);
    assign n0_num_y_next = norm_num(s_tdata[15:8], hy);
    assign n0_num_z_next = norm_num(s_tdata[23:16], hz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n0_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            n0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            n0_num_x_reg <= n0_num_x_next;
            n0_num_y_reg <= n0_num_y_next;
            n0_num_z_reg <= n0_num_z_next;
            n0_h_x_reg   <= hx;
            n0_h_y_reg   <= hy;
            n0_h_z_reg   <= hz;
            n0_smp_reg   <= s_tdata[3*IDX_W +: 2*SB];
        end
    end

    // ------------------------------------------------------------------
    // Axis normalization: three dividers in lockstep; x carries the sample.
    // ------------------------------------------------------------------
    logic             nd_vld;
    logic [NRM_W-1:0] nx, ny, nz;
    logic [2*SB-1:0]  nd_smp;

    rtkw_div #(.NUM_W(NRM_W), .DEN_W(IDX_W), .STEP(DIV_STEP), .SIDE_W(2*SB)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_vld(n0_vld_reg),
        .num(n0_num_x_reg), .den(n0_h_x_reg), .side_in(n0_smp_reg),
        .out_vld(nd_vld), .quo(nx), .side_out(nd_smp)
    );

    rtkw_div #(.NUM_W(NRM_W), .DEN_W(IDX_W), .STEP(DIV_STEP), .SIDE_W(1)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_vld(n0_vld_reg),
        .num(n0_num_y_reg), .den(n0_h_y_reg), .side_in(n0_vld_reg),
        .out_vld(), .quo(ny), .side_out()
    );

    rtkw_div #(.NUM_W(NRM_W), .DEN_W(IDX_W), .STEP(DIV_STEP), .SIDE_W(1)) u_div_z (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_vld(n0_vld_reg),
        .num(n0_num_z_reg), .den(n0_h_z_reg), .side_in(n0_vld_reg),
        .out_vld(), .quo(nz), .side_out()
    );

    // ------------------------------------------------------------------
    // Squares, then their sum.
    // ------------------------------------------------------------------
    logic               sq_vld_reg, ss_vld_reg;
    logic [2*NRM_W-1:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SSQ_W-1:0]   ss_reg, ss_next;
    logic [2*SB-1:0]    sq_smp_reg, ss_smp_reg;

    assign ss_next = SSQ_W'(sq_x_reg) + SSQ_W'(sq_y_reg) + SSQ_W'(sq_z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
            ss_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            sq_vld_reg <= nd_vld;
            ss_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq_x_reg   <= nx * nx;
            sq_y_reg   <= ny * ny;
            sq_z_reg   <= nz * nz;
            sq_smp_reg <= nd_smp;
            ss_reg     <= ss_next;
            ss_smp_reg <= sq_smp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Radius.
    // ------------------------------------------------------------------
    logic              rt_vld;
    logic [ROOT_W-1:0] rt_r;
    logic [2*SB-1:0]   rt_smp;

    rtkw_isqrt #(.IN_W(SSQ_W), .STEP(SQRT_STEP), .SIDE_W(2*SB)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_vld(ss_vld_reg),
        .rad(ss_reg), .side_in(ss_smp_reg),
        .out_vld(rt_vld), .root(rt_r), .side_out(rt_smp)
    );

    // ------------------------------------------------------------------
    // Weight class and taper phase numerator and denominator.
    // ------------------------------------------------------------------
    wclass_t          cl_cls_reg, cl_cls_next;
    logic             cl_vld_reg;
    logic [RAD_W-1:0] cl_num_reg, cl_den_reg;
    logic [2*SB-1:0]  cl_smp_reg;

    always_comb begin
        priority if (rt_r <= ROOT_W'(start_reg)) begin
            cl_cls_next = WCLS_ONE;
        end else if (rt_r > ROOT_W'(end_reg)) begin
            cl_cls_next = WCLS_ZERO;
        end else begin
            cl_cls_next = WCLS_TAPER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            cl_vld_reg <= rt_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cl_cls_reg <= cl_cls_next;
            // Inside the taper the radius is at most the end radius.
            cl_num_reg <= rt_r[RAD_W-1:0] - start_reg;
            cl_den_reg <= end_reg - start_reg;
            cl_smp_reg <= rt_smp;
        end
    end

    logic                   ph_vld;
    logic [SSQ_W-1:0]       ph_quo;
    logic [2*SB+1:0]        ph_side;

    rtkw_div #(.NUM_W(SSQ_W), .DEN_W(RAD_W), .STEP(DIV_STEP), .SIDE_W(2*SB+2)) u_div_ph (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_vld(cl_vld_reg),
        .num({cl_num_reg, 30'b0}), .den(cl_den_reg),
        .side_in({cl_cls_reg, cl_smp_reg}),
        .out_vld(ph_vld), .quo(ph_quo), .side_out(ph_side)
    );

    // ------------------------------------------------------------------
    // Taper weight.
    // ------------------------------------------------------------------
    logic            tp_vld;
    logic [W_W-1:0]  tp_w;
    logic [2*SB-1:0] tp_smp;

    rtkw_taper #(.SIDE_W(2*SB)) u_taper (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_vld(ph_vld),
        .phase(ph_quo[PH_W-1:0]), .cls(wclass_t'(ph_side[2*SB +: 2])),
        .hgt(floor_reg), .side_in(ph_side[2*SB-1:0]),
        .out_vld(tp_vld), .w(tp_w), .side_out(tp_smp)
    );

    // ------------------------------------------------------------------
    // Scaling: magnitude times weight, then rounding into the output register.
    // ------------------------------------------------------------------
    logic [SB-1:0]  sc_re, sc_im, mag_re, mag_im;
    logic           s1_vld_reg;
    logic           s1_neg_re_reg, s1_neg_im_reg;
    logic [SB+15:0] s1_prod_re_reg, s1_prod_im_reg;

    assign sc_re  = tp_smp[SB-1:0];
    assign sc_im  = tp_smp[2*SB-1:SB];
    // The most negative value maps onto its own bit pattern, which is the
    // right magnitude when read as unsigned.
    assign mag_re = sc_re[SB-1] ? (~sc_re) + SB'(1) : sc_re;
    assign mag_im = sc_im[SB-1] ? (~sc_im) + SB'(1) : sc_im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_vld_reg   <= tp_vld;
            m_tvalid_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_neg_re_reg  <= sc_re[SB-1];
            s1_neg_im_reg  <= sc_im[SB-1];
            s1_prod_re_reg <= mag_re * tp_w;
            s1_prod_im_reg <= mag_im * tp_w;
            m_tdata_reg    <= OUT_W'({round_sat(s1_prod_im_reg, s1_neg_im_reg),
                                      round_sat(s1_prod_re_reg, s1_neg_re_reg)});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `RTKW_ASSERT(a_weight_le_one, aclk, aresetn, tp_vld |-> (tp_w <= ONE_Q15), "weight above one")
    `RTKW_ASSERT(a_stall_holds, aclk, aresetn, !pipe_en |=> ($stable(tp_vld) && $stable(tp_w)), "taper moved during stall")
    `RTKW_ASSERT(a_zero_weight, aclk, aresetn, (tp_vld && pipe_en && tp_w == '0) |=> (s1_prod_re_reg == '0 && s1_prod_im_reg == '0), "zero weight gave nonzero product")
    `RTKW_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid_reg, "output valid after reset")

endmodule
